// ===== design/stft_pkg.sv =====
// Package: payload structs, cosine table and fixed constants for the STFT spectrogram.
`default_nettype none
package stft_pkg;

  // frame length and used sample bits; the datapath widths are built for these values
  localparam int FFT_SIZE    = 64;
  localparam int SAMPLE_BITS = 16;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic               new_capture;
  } stft_in_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [15:0] power_db;
    logic [31:0]        frame_start;
    logic               last_bin;
  } stft_out_t;

  localparam int DB_PER_LOG2_Q16 = 197283;
  localparam logic [15:0] DB_FLOOR = 16'h8000;

  // Q15 cosine of t*2*pi/64, t taken mod 64
  function automatic logic signed [16:0] cos64(input logic [5:0] t);
    logic [4:0] a;
    logic neg;
    logic [16:0] v;
    begin
      neg = 1'b0;
      a = 5'd0;
      if (t <= 6'd16) begin
        a = t[4:0];
      end else if (t <= 6'd32) begin
        a = 5'(6'd32 - t); neg = 1'b1;
      end else if (t <= 6'd48) begin
        a = 5'(t - 6'd32); neg = 1'b1;
      end else begin
        a = 5'(7'd64 - {1'b0, t});
      end
      case (a)
        5'd0:  v = 17'd32768;
        5'd1:  v = 17'd32610;
        5'd2:  v = 17'd32138;
        5'd3:  v = 17'd31357;
        5'd4:  v = 17'd30274;
        5'd5:  v = 17'd28899;
        5'd6:  v = 17'd27246;
        5'd7:  v = 17'd25330;
        5'd8:  v = 17'd23170;
        5'd9:  v = 17'd20788;
        5'd10: v = 17'd18205;
        5'd11: v = 17'd15447;
        5'd12: v = 17'd12540;
        5'd13: v = 17'd9512;
        5'd14: v = 17'd6393;
        5'd15: v = 17'd3212;
        default: v = 17'd0;
      endcase
      cos64 = neg ? -$signed(v) : $signed(v);
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/stft_power_db_spectrogram.sv =====
// Top level: STFT power spectrogram in dB with one shared multiply-accumulate unit.
`default_nettype none
// Complex I/Q samples stream into a FFT_SIZE-deep ring. From the first sample of a
// capture, a frame is complete after FFT_SIZE samples and then every hop_length
// samples (hop 0 acts as 1). A sample that completes no frame is accepted and
// in_ready stays high. A completing sample starts a frame job: the ring is windowed
// into the work memory (ring read, then multiply and write, per sample), then the
// log unit takes log2(3*FFT_SIZE) once. Each bin is a direct DFT on one shared
// complex MAC: a setup step, the accumulation (work read, then MAC), squaring of
// the real and imaginary sums in 32-bit partial products, a normalize step, a log2
// sequencer of 16 squaring steps, dB scaling and a transfer; a zero-power bin skips
// the log2 and scale steps. The frame rate is set by the single MAC and log unit;
// the input is not ready while a frame runs. Each bin result sits in an output
// register and the next bin starts after it transfers. Bins come out in row order;
// with centered_order set, row r carries bin (r + M - M/2) mod M. Power is
// |X|^2/(3*FFT_SIZE/8) as 10*log10 in signed Q7.8; zero power reads -32768 and
// large values saturate. Configuration writes take effect at once; write only
// while idle.
module stft_power_db_spectrogram (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire stft_pkg::stft_in_t   in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      stft_pkg::stft_out_t  out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [6:0]           cfg_wdata
);
  import stft_pkg::*;

  localparam int AW = $clog2(FFT_SIZE);
  localparam logic [AW:0] SIZE_C = AW'(0) + (AW+1)'(FFT_SIZE);
  localparam logic [AW:0] HALF_C = (AW+1)'(FFT_SIZE / 2);
  // log2(3*FFT_SIZE) in Q16, done with real math at elaboration would be imprecise;
  // computed at runtime once per frame by the same log unit instead.
  localparam int CFG_HOP = 0;

  typedef enum logic [3:0] {
    S_IDLE, S_WIN_RD, S_WIN, S_REF, S_MAC_RD, S_MAC, S_SQ, S_NORM,
    S_LOG, S_SCALE, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  hop_length;
  logic        centered_order;
  logic [31:0] sample_count;
  logic [6:0]  hop_countdown;
  logic [AW-1:0] ring_pos;
  logic        capture_open;
  logic [31:0] frame_start;

  logic signed [31:0] ring_mem [FFT_SIZE];
  logic signed [31:0] ring_rd;
  logic signed [63:0] work_mem [FFT_SIZE];
  logic signed [63:0] work_rd;

  logic [AW:0]   n;        // sample counter
  logic [AW:0]   row;      // output row
  logic [AW-1:0] k;        // bin in use
  logic [AW-1:0] nk;       // (n*k) mod FFT_SIZE, stepped by k
  logic signed [63:0] acc_re, acc_im;
  logic [63:0]  mag_a, mag_b;
  logic [127:0] m;
  logic [1:0]   sq_step;
  logic         ref_mode;  // log unit busy on 3*FFT_SIZE reference
  logic [7:0]   e;
  logic [32:0]  y;
  logic [63:0]  ysq;
  logic [4:0]   li;
  logic [1:0]   lph;
  logic [15:0]  frac;
  logic signed [31:0] ref_q16;
  logic signed [31:0] lp;
  logic signed [55:0] prod;
  logic [1:0]   sc_step;
  logic [31:0]  sqa_x, sqa_y, sqb_x, sqb_y;

  // sign-extend the low SAMPLE_BITS bits
  function automatic logic signed [15:0] sext(input logic [15:0] v);
    logic [15:0] r;
    begin
      r = v;
      for (int b = SAMPLE_BITS; b < 16; b++) r[b] = v[SAMPLE_BITS-1];
      sext = $signed(r);
    end
  endfunction

  function automatic logic [5:0] angle_of(input logic [AW-1:0] p);
    logic [AW+6:0] t;
    begin
      t = ({7'd0, p} << 6) + (AW+7)'(FFT_SIZE / 2);
      angle_of = 6'(t / (AW+7)'(FFT_SIZE));
    end
  endfunction

  assign in_ready = (state == S_IDLE) && !rst;

  wire in_fire = in_valid && in_ready;
  wire restart = in_data.new_capture || !capture_open;
  wire [6:0] cd_now = restart ? 7'(FFT_SIZE - 1) : hop_countdown;
  wire [6:0] hop = (hop_length == 7'd0) ? 7'd1 : hop_length;
  wire [31:0] cur = restart ? 32'd0 : sample_count;

  // window multiply (registered work write)
  wire [AW-1:0] widx = AW'(ring_pos + AW'(1) + n[AW-1:0]);
  wire signed [17:0] w2 = 18'sd32768 - 18'(cos64(angle_of(n[AW-1:0])));
  wire signed [49:0] wpi = $signed(ring_rd[31:16]) * w2;
  wire signed [49:0] wpq = $signed(ring_rd[15:0]) * w2;

  // shared complex MAC
  wire [5:0] ang = angle_of(nk);
  wire signed [16:0] cc = cos64(ang);
  wire signed [16:0] ss = cos64(6'(ang + 6'd48));
  wire signed [31:0] xr = work_rd[63:32];
  wire signed [31:0] xi = work_rd[31:0];
  wire signed [48:0] p_rc = xr * cc;
  wire signed [48:0] p_is = xi * ss;
  wire signed [48:0] p_ic = xi * cc;
  wire signed [48:0] p_rs = xr * ss;

  // squaring operands: low*low, high*low, then high*high
  always_comb begin
    case (sq_step)
      2'd1: begin
        sqa_x = mag_a[31:0];  sqa_y = mag_a[31:0];
        sqb_x = mag_b[31:0];  sqb_y = mag_b[31:0];
      end
      2'd2: begin
        sqa_x = mag_a[63:32]; sqa_y = mag_a[31:0];
        sqb_x = mag_b[63:32]; sqb_y = mag_b[31:0];
      end
      default: begin
        sqa_x = mag_a[63:32]; sqa_y = mag_a[63:32];
        sqb_x = mag_b[63:32]; sqb_y = mag_b[63:32];
      end
    endcase
  end
  wire [63:0] sq_pa = sqa_x * sqa_y;
  wire [63:0] sq_pb = sqb_x * sqb_y;

  // top set bit of m
  logic [7:0] msb_m;
  always_comb begin
    msb_m = 8'd0;
    for (int b = 0; b < 128; b++) if (m[b]) msb_m = 8'(b);
  end
  wire signed [8:0] sh = $signed({1'b0, msb_m}) - 9'sd31;
  wire [127:0] norm_v = sh[8] ? (m << 7'(-sh)) : (m >> sh[7:0]);

  always_ff @(posedge clk) begin
    if (in_fire) ring_mem[ring_pos] <= {sext(in_data.sample_i), sext(in_data.sample_q)};
    ring_rd <= ring_mem[widx];
    if (state == S_WIN)
      work_mem[n[AW-1:0]] <= {32'(wpi >>> 8), 32'(wpq >>> 8)};
    work_rd <= work_mem[n[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hop_length <= 7'd32;
      centered_order <= 1'b0;
      sample_count <= 32'd0;
      hop_countdown <= 7'd0;
      ring_pos <= '0;
      capture_open <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_HOP)) hop_length <= cfg_wdata;
        else centered_order <= cfg_wdata[0];
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            capture_open <= 1'b1;
            sample_count <= cur + 32'd1;
            if (cd_now == 7'd0) begin
              hop_countdown <= 7'(hop - 7'd1);
              frame_start <= cur - 32'(FFT_SIZE - 1);
              n <= '0;
              state <= S_WIN_RD;
            end else begin
              hop_countdown <= cd_now - 7'd1;
              ring_pos <= AW'(ring_pos + AW'(1));
            end
          end
        end
        S_WIN_RD: state <= S_WIN;  // ring read latency
        S_WIN: begin
          if (n == SIZE_C - 1'b1) begin
            ring_pos <= AW'(ring_pos + AW'(1));
            // reference log2(3*FFT_SIZE)
            m <= 128'(3 * FFT_SIZE);
            ref_mode <= 1'b1;
            row <= '0;
            state <= S_NORM;
          end else begin
            n <= n + 1'b1;
            state <= S_WIN_RD;
          end
        end
        S_MAC_RD: state <= S_MAC;
        S_MAC: begin
          acc_re <= acc_re + 64'(p_rc) + 64'(p_is);
          acc_im <= acc_im + 64'(p_ic) - 64'(p_rs);
          nk <= AW'(nk + k);
          if (n == SIZE_C - 1'b1) begin
            sq_step <= 2'd0;
            m <= '0;
            state <= S_SQ;
          end else begin
            n <= n + 1'b1;
            state <= S_MAC_RD;
          end
        end
        S_SQ: begin
          // first the magnitudes, then one 32x32 partial product per step for both
          if (sq_step == 2'd0) begin
            mag_a <= acc_re[63] ? 64'(-acc_re) : 64'(acc_re);
            mag_b <= acc_im[63] ? 64'(-acc_im) : 64'(acc_im);
            sq_step <= 2'd1;
          end else if (sq_step == 2'd1) begin
            m <= {64'd0, sq_pa} + {64'd0, sq_pb};
            sq_step <= 2'd2;
          end else if (sq_step == 2'd2) begin
            m <= m + ({64'd0, sq_pa} << 33) + ({64'd0, sq_pb} << 33);
            sq_step <= 2'd3;
          end else begin
            m <= m + {sq_pa, 64'd0} + {sq_pb, 64'd0};
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (m == 128'd0) begin
            out_data.power_db <= DB_FLOOR;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            e <= msb_m;
            y <= {1'b0, norm_v[31:0]};
            frac <= '0;
            li <= '0;
            lph <= '0;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          // each fraction bit: square, shift, test
          if (lph == 2'd0) begin
            ysq <= y[31:0] * y[31:0];
            lph <= 2'd1;
          end else if (lph == 2'd1) begin
            y <= 33'(ysq >> 31);
            lph <= 2'd2;
          end else begin
            frac <= {frac[14:0], y[32]};
            if (y[32]) y <= y >> 1;
            lph <= 2'd0;
            li <= li + 1'b1;
            if (li == 5'd15) begin
              if (ref_mode) begin
                ref_q16 <= $signed({8'd0, e, frac[14:0], y[32]});
                ref_mode <= 1'b0;
                state <= S_REF;
              end else begin
                lp <= $signed({8'd0, e, frac[14:0], y[32]}) - ref_q16
                      - 32'sd2818048;
                sc_step <= 2'd0;
                state <= S_SCALE;
              end
            end
          end
        end
        S_REF: begin
          // start the bin at this row; row fields settle before valid rises
          k <= centered_order ? AW'(row[AW-1:0] + AW'(SIZE_C - HALF_C))
                              : row[AW-1:0];
          out_data.bin_index <= 6'(row);
          out_data.frame_start <= frame_start;
          out_data.last_bin <= (row == SIZE_C - 1'b1);
          n <= '0;
          nk <= '0;
          acc_re <= '0;
          acc_im <= '0;
          state <= S_MAC_RD;
        end
        S_SCALE: begin
          if (sc_step == 2'd0) begin
            prod <= lp * 56'sd197283 + 56'sd8388608;
            sc_step <= 2'd1;
          end else begin
            if ((prod >>> 24) > 56'sd32767) out_data.power_db <= 16'sd32767;
            else if ((prod >>> 24) < -56'sd32768) out_data.power_db <= DB_FLOOR;
            else out_data.power_db <= 16'(prod >>> 24);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (row == SIZE_C - 1'b1) begin
              state <= S_IDLE;
            end else begin
              row <= row + 1'b1;
              state <= S_REF;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for stft_power_db_spectrogram: directed table plus random phases, scored per bin.
`default_nettype none
module testbench;
  import stft_pkg::*;

  localparam int N          = 64;
  localparam int LIMIT      = 20000000;
  localparam bit REG_HOP    = 1'b0;
  localparam bit REG_CENTER = 1'b1;

  // Q15 cosine, first quadrant, 1/64 turn per step
  localparam int QCOS [0:16] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                                 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  stft_in_t    in_data;
  stft_out_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_wdata;

  stft_power_db_spectrogram dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Spectrogram predictor: own copy of ring, window buffer, counters, registers
  // ---------------------------------------------------------------------------
  int          iq_ring [N][2];
  longint      win_buf [N][2];
  int unsigned cap_count;
  int unsigned hop_left;
  int unsigned wr_pos;
  bit          cap_open;
  int unsigned hop_reg;
  bit          center_reg;
  stft_out_t   bins_due [$];

  function automatic longint qcos64(int unsigned t);
    t = t & 63;
    if (t <= 16) return QCOS[t];
    if (t <= 32) return -QCOS[32 - t];
    if (t <= 48) return -QCOS[t - 32];
    return QCOS[64 - t];
  endfunction

  function automatic int unsigned tbl_angle(int unsigned p);
    return ((p * 64 + N / 2) / N) & 63;
  endfunction

  // log2 in Q16: integer part is the top set bit, fraction by repeated squaring
  function automatic longint log2_fix(logic [127:0] m);
    int          e;
    logic [63:0] y;
    longint      frac;
    e = 0;
    frac = 0;
    for (int b = 0; b < 128; b++) if (m[b]) e = b;
    if (e >= 31) y = 64'(m >> (e - 31));
    else y = 64'(m << (31 - e));
    y = y & 64'hFFFF_FFFF;
    for (int s = 0; s < 16; s++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic logic [15:0] bin_power_db(int unsigned k);
    longint       re, im, c, s, lp, t, q, a, b;
    int unsigned  ang;
    logic [127:0] m;
    re = 0;
    im = 0;
    for (int unsigned n = 0; n < N; n++) begin
      ang = tbl_angle((n * k) % N);
      c = qcos64(ang);
      s = qcos64(ang + 48);
      re += win_buf[n][0] * c + win_buf[n][1] * s;
      im += win_buf[n][1] * c - win_buf[n][0] * s;
    end
    a = re < 0 ? -re : re;
    b = im < 0 ? -im : im;
    m = 128'(a) * 128'(a) + 128'(b) * 128'(b);
    if (m == 0) return DB_FLOOR;
    lp = log2_fix(m) - log2_fix(128'(3 * N)) - 64'sd43 * 65536;
    t = lp * DB_PER_LOG2_Q16 + (64'sd1 <<< 23);
    q = t >>> 24;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // advance the predictor by one accepted sample; queue a frame if one completes
  task automatic predict_sample(input stft_in_t it, input bit floor_frame);
    int unsigned hop, cur, idx, k;
    bit          fire;
    longint      w2;
    stft_out_t   r;
    hop = (hop_reg == 0) ? 1 : hop_reg;
    if (it.new_capture || !cap_open) begin
      cap_open = 1'b1;
      cap_count = 0;
      hop_left = N - 1;
    end
    iq_ring[wr_pos][0] = it.sample_i;
    iq_ring[wr_pos][1] = it.sample_q;
    cur = cap_count;
    cap_count = cap_count + 1;
    fire = (hop_left == 0);
    hop_left = fire ? ((hop - 1) & 127) : hop_left - 1;
    if (fire) begin
      for (int unsigned n = 0; n < N; n++) begin
        idx = (wr_pos + 1 + n) % N;
        w2 = 32768 - qcos64(tbl_angle(n));
        win_buf[n][0] = (longint'(iq_ring[idx][0]) * w2) >>> 8;
        win_buf[n][1] = (longint'(iq_ring[idx][1]) * w2) >>> 8;
      end
      for (int unsigned row = 0; row < N; row++) begin
        k = center_reg ? (row + N - N / 2) % N : row;
        r.bin_index   = 6'(row);
        r.power_db    = floor_frame ? DB_FLOOR : bin_power_db(k);
        r.frame_start = cur - (N - 1);
        r.last_bin    = (row == N - 1);
        bins_due = {bins_due, r};
      end
    end
    wr_pos = (wr_pos + 1) % N;
  endtask

  // ---------------------------------------------------------------------------
  // Result scoreboard
  // ---------------------------------------------------------------------------
  int        n_bad;
  stft_out_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected bin transfer: %p", out_data);
      end else begin
        want = bins_due.pop_front();
        if (out_data.bin_index !== want.bin_index || out_data.power_db !== want.power_db ||
            out_data.frame_start !== want.frame_start || out_data.last_bin !== want.last_bin)
        begin
          n_bad++;
          if (n_bad <= 10) $display("bin mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // receiver stall pattern: free-flowing, coin-flip, then mostly stalled
  int unsigned rx_cyc;
  always @(negedge clk) begin
    rx_cyc++;
    case ((rx_cyc / 700) % 3)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= (rx_cyc % 5 == 0);
      end
    endcase
  end

  // watchdog
  int unsigned cyc;
  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_sample(input stft_in_t it, input bit floor_frame);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_sample(it, floor_frame);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      // every so often a long unbroken burst
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
    end
  endtask

  // drain, let any in-flight non-frame sample settle, then write a register
  task automatic write_reg(input bit idx, input logic [6:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    while (bins_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_HOP) hop_reg = val;
    else center_reg = val[0];
  endtask

  function automatic logic signed [15:0] rand_sample(int unsigned kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15)) - 16'sd8;
      2: return 16'sd0;
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // mostly continuing captures with random content, occasional restarts
  task automatic random_phase(input int unsigned n_items);
    stft_in_t    it;
    int unsigned kind;
    kind = $urandom_range(0, 3);
    for (int unsigned j = 0; j < n_items; j++) begin
      if ($urandom_range(0, 15) == 0) kind = $urandom_range(0, 3);
      it.sample_i    = rand_sample(kind);
      it.sample_q    = rand_sample(kind);
      it.new_capture = ($urandom_range(0, 99) < 3);
      send_sample(it, 1'b0);
    end
  endtask

  // directed rows: sample, repeat count; new_capture only on the first repeat
  typedef struct {
    logic signed [15:0] si;
    logic signed [15:0] sq;
    bit                 nc;
    int unsigned        reps;
    bit                 floor_frame;
  } stim_row_t;

  stim_row_t rows [$];
  stft_in_t  item;

  task automatic add_row(input logic signed [15:0] si, input logic signed [15:0] sq,
                         input bit nc, input int unsigned reps, input bit floor_frame);
    stim_row_t sr;
    sr.si          = si;
    sr.sq          = sq;
    sr.nc          = nc;
    sr.reps        = reps;
    sr.floor_frame = floor_frame;
    rows = {rows, sr};
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = 1'b0;
    cfg_wdata  = '0;
    out_ready  = 1'b0;
    n_bad      = 0;
    cyc        = 0;
    rx_cyc     = 0;
    burst_left = 5;
    cap_count  = 0;
    hop_left   = 0;
    wr_pos     = 0;
    cap_open   = 1'b0;
    hop_reg    = 32;
    center_reg = 1'b0;
    foreach (iq_ring[n]) begin
      iq_ring[n][0] = 0;
      iq_ring[n][1] = 0;
      win_buf[n][0] = 0;
      win_buf[n][1] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings (hop 32, natural order); first sample opens a capture on its own,
    // zero input frame reads the floor in every bin
    add_row(16'sd0, 16'sd0, 1'b0, 64, 1'b1);
    add_row(16'sh7FFF, 16'sh8000, 1'b0, 32, 1'b0);
    add_row(16'sh8000, 16'sh7FFF, 1'b0, 32, 1'b0);
    add_row(16'sd1, -16'sd1, 1'b0, 16, 1'b0);
    add_row(-16'sd1, 16'sd0, 1'b0, 16, 1'b0);
    // restart mid-stream, zero frame again
    add_row(16'sd0, 16'sd0, 1'b1, 64, 1'b1);
    foreach (rows[r]) begin
      for (int unsigned j = 0; j < rows[r].reps; j++) begin
        item.sample_i    = rows[r].si;
        item.sample_q    = rows[r].sq;
        item.new_capture = rows[r].nc && (j == 0);
        send_sample(item, rows[r].floor_frame);
      end
    end

    // hop 64, centered rows
    write_reg(REG_HOP, 7'd64);
    write_reg(REG_CENTER, 1'b1);
    random_phase(50);
    // hop 1: every sample ends a frame
    write_reg(REG_HOP, 7'd1);
    random_phase(10);
    // hop 0 behaves as 1
    write_reg(REG_HOP, 7'd0);
    write_reg(REG_CENTER, 1'b0);
    random_phase(8);
    // random settings
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_HOP, 7'($urandom_range(6, 64)));
      write_reg(REG_CENTER, 1'($urandom_range(0, 1)));
      random_phase(30);
    end

    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (n_bad == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
